// ===== design/rlh_pkg.sv =====
// Shared types, codes and constants for the region luma histogram block.
// Standalone package; used by region_luma_histogram_top.
package rlh_pkg;

	localparam int LINE_WIDTH = 1024;
	localparam int LINE_COUNT = 1024;
	localparam int COL_W      = $clog2(LINE_WIDTH);
	localparam int ROW_W      = $clog2(LINE_COUNT);

	localparam int FIRST_W    = 10;
	localparam int END_W      = 11;
	// width that holds a position and a window edge alike
	localparam int CMP_W      = (COL_W > END_W) ? ((ROW_W > COL_W) ? ROW_W : COL_W)
	                          : ((ROW_W > END_W) ? ROW_W : END_W);

	localparam int BIN_W      = 21;
	localparam int BINS       = 256;
	localparam int LUMA_W     = $clog2(BINS);
	localparam int HEIGHT_W   = 8;
	localparam int NUM_W      = BIN_W + HEIGHT_W;
	localparam int PROD_W     = 24;
	localparam int STEP_W     = $clog2(HEIGHT_W);

	localparam logic [BIN_W-1:0]    BIN_MAX  = {BIN_W{1'b1}};
	localparam logic [HEIGHT_W-1:0] BAR_FULL = 8'd150;

	// Q16 luma weights
	localparam logic [15:0] WEIGHT_R = 16'd19588;
	localparam logic [15:0] WEIGHT_G = 16'd38469;
	localparam logic [15:0] WEIGHT_B = 16'd7477;

	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_PIXEL = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_FIRST = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_X_END   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_FIRST = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_Y_END   = 3'd4;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] bin_index;
	} req_t;

	typedef struct packed {
		logic [BIN_W-1:0]    bin_count;
		logic [HEIGHT_W-1:0] bar_height;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADDR,
		ST_UPD,
		ST_RD,
		ST_DIV,
		ST_OUT
	} state_t;

endpackage

// ===== design/region_luma_histogram_top.sv =====
// Region luma histogram: 256-bin luma count over a window of a raster frame.
// Depends on rlh_pkg for types, codes and constants.
//
// Usage:
//   Requests arrive on req (valid/stall); one action per request: clear,
//   pixel or read bin. Only a read bin request gives a response on rsp
//   (valid/stall), carrying the raw count and the bar height scaled so the
//   peak bin reads 150.
//   Configuration writes (enable, window edges) go through cfg_valid/ready,
//   always ready; the user must make them while the block is idle (not enforced).
// Request handling, one request at a time:
//   clear, uncounted pixel: handled in idle, without stalling req.
//   counted pixel: req stalls through the read-modify-write of the bin memory
//   (multiply, address and read, write back).
//   read bin: req stalls until the response register is loaded, through the
//   8-step restoring divider for count*150/peak, which is skipped while the peak
//   is zero; req stalls longer while rsp is stalled, since one finished response
//   waits in the output register while the next request is taken.
// Reset: all bins read as zero through per-bin valid flags, peak, position
// and configuration registers are zero; no clearing pass is needed. A clear
// request or writing enable to 0 empties the bins the same way.
module region_luma_histogram_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  rlh_pkg::req_t                    req,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output rlh_pkg::rsp_t                    rsp,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rlh_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rlh_pkg::CFG_DATA_W-1:0]   cfg_data
);

	rlh_pkg::state_t state_q, state_d;

	logic                         enable_q;
	logic [rlh_pkg::FIRST_W-1:0]  x_first_q, y_first_q;
	logic [rlh_pkg::END_W-1:0]    x_end_q, y_end_q;
	logic [rlh_pkg::COL_W-1:0]    column_q;
	logic [rlh_pkg::ROW_W-1:0]    row_q;
	logic [rlh_pkg::BIN_W-1:0]    peak_q;
	logic [rlh_pkg::BINS-1:0]     bin_vld_q;

	logic [rlh_pkg::BIN_W-1:0]    bin_mem [rlh_pkg::BINS];
	logic [rlh_pkg::BIN_W-1:0]    rd_data_s2;
	logic                         rd_vld_s2;
	logic [rlh_pkg::LUMA_W-1:0]   addr_q;

	logic [7:0]                   red_q, green_q, blue_q;
	logic [rlh_pkg::PROD_W-1:0]   prod_r_q, prod_g_q, prod_b_q;
	logic [rlh_pkg::PROD_W-1:0]   luma_sum;

	logic [rlh_pkg::BIN_W-1:0]    count_q;
	logic [rlh_pkg::NUM_W-1:0]    rem_q;
	logic [rlh_pkg::NUM_W-1:0]    trial;
	logic [rlh_pkg::STEP_W-1:0]   step_q;
	logic [rlh_pkg::HEIGHT_W-1:0] quo_q;
	logic [rlh_pkg::HEIGHT_W-1:0] height;

	logic                         rsp_valid_q;
	rlh_pkg::rsp_t                rsp_q;

	logic take, take_clear, take_pixel, take_read, count_pixel;
	logic rd_en, wr_en, out_load, cfg_wr, cfg_disable;
	logic [rlh_pkg::LUMA_W-1:0]   rd_addr;
	logic [rlh_pkg::BIN_W-1:0]    cnt_now, cnt_new;

	logic [rlh_pkg::CMP_W-1:0] col_c, row_c, x_a, x_b, y_a, y_b;
	logic [rlh_pkg::CMP_W-1:0] x_lo, x_hi, y_lo, y_hi;
	logic in_window;

	assign cfg_ready   = 1'b1;
	assign cfg_wr      = cfg_valid && cfg_ready;
	assign cfg_disable = cfg_wr && (cfg_index == rlh_pkg::REG_ENABLE) && !cfg_data[0];

	assign take        = req_valid && !req_stall;
	assign take_clear  = take && (req.action == rlh_pkg::ACT_CLEAR);
	assign take_pixel  = take && (req.action == rlh_pkg::ACT_PIXEL);
	assign take_read   = take && (req.action == rlh_pkg::ACT_READ);

	// window test against the position of the arriving pixel
	always_comb begin
		col_c = rlh_pkg::CMP_W'(column_q);
		row_c = rlh_pkg::CMP_W'(row_q);
		x_a   = rlh_pkg::CMP_W'(x_first_q);
		x_b   = rlh_pkg::CMP_W'(x_end_q);
		y_a   = rlh_pkg::CMP_W'(y_first_q);
		y_b   = rlh_pkg::CMP_W'(y_end_q);
		x_lo  = (x_a <= x_b) ? x_a : x_b;
		x_hi  = (x_a <= x_b) ? x_b : x_a;
		y_lo  = (y_a <= y_b) ? y_a : y_b;
		y_hi  = (y_a <= y_b) ? y_b : y_a;
		in_window = (col_c >= x_lo) && (col_c < x_hi) && (row_c >= y_lo) && (row_c < y_hi);
	end

	assign count_pixel = take_pixel && enable_q && in_window;

	assign luma_sum = prod_r_q + prod_g_q + prod_b_q;
	assign cnt_now  = rd_vld_s2 ? rd_data_s2 : '0;
	assign cnt_new  = (cnt_now == rlh_pkg::BIN_MAX) ? cnt_now : cnt_now + 1'b1;
	assign trial    = rlh_pkg::NUM_W'(peak_q) << step_q;
	assign height   = (quo_q > rlh_pkg::BAR_FULL) ? rlh_pkg::BAR_FULL : quo_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rlh_pkg::ST_IDLE: begin
				if (count_pixel) begin
					state_d = rlh_pkg::ST_MUL;
				end else if (take_read) begin
					state_d = rlh_pkg::ST_RD;
				end
			end
			rlh_pkg::ST_MUL:  state_d = rlh_pkg::ST_ADDR;
			rlh_pkg::ST_ADDR: state_d = rlh_pkg::ST_UPD;
			rlh_pkg::ST_UPD:  state_d = rlh_pkg::ST_IDLE;
			rlh_pkg::ST_RD: begin
				state_d = (peak_q == '0) ? rlh_pkg::ST_OUT : rlh_pkg::ST_DIV;
			end
			rlh_pkg::ST_DIV: begin
				if (step_q == '0) begin
					state_d = rlh_pkg::ST_OUT;
				end
			end
			rlh_pkg::ST_OUT: begin
				if (out_load) begin
					state_d = rlh_pkg::ST_IDLE;
				end
			end
			default: state_d = rlh_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		req_stall = 1'b1;
		rd_en     = 1'b0;
		rd_addr   = req.bin_index;
		wr_en     = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			rlh_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				rd_en     = take_read;
			end
			rlh_pkg::ST_ADDR: begin
				rd_en   = 1'b1;
				rd_addr = luma_sum[rlh_pkg::PROD_W-1 -: rlh_pkg::LUMA_W];
			end
			rlh_pkg::ST_UPD: wr_en = 1'b1;
			rlh_pkg::ST_OUT: out_load = !rsp_valid_q || !rsp_stall;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rlh_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			x_first_q <= '0;
			x_end_q   <= '0;
			y_first_q <= '0;
			y_end_q   <= '0;
		end else if (cfg_wr) begin
			case (cfg_index)
				rlh_pkg::REG_ENABLE:  enable_q  <= cfg_data[0];
				rlh_pkg::REG_X_FIRST: x_first_q <= cfg_data[rlh_pkg::FIRST_W-1:0];
				rlh_pkg::REG_X_END:   x_end_q   <= cfg_data[rlh_pkg::END_W-1:0];
				rlh_pkg::REG_Y_FIRST: y_first_q <= cfg_data[rlh_pkg::FIRST_W-1:0];
				rlh_pkg::REG_Y_END:   y_end_q   <= cfg_data[rlh_pkg::END_W-1:0];
				default: ;
			endcase
		end
	end

	// raster position; advances on every pixel request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
		end else if (take_clear) begin
			column_q <= '0;
			row_q    <= '0;
		end else if (take_pixel) begin
			if (column_q == rlh_pkg::COL_W'(rlh_pkg::LINE_WIDTH - 1)) begin
				column_q <= '0;
				row_q    <= (row_q == rlh_pkg::ROW_W'(rlh_pkg::LINE_COUNT - 1)) ? '0 : row_q + 1'b1;
			end else begin
				column_q <= column_q + 1'b1;
			end
		end
	end

	// bin valid flags and running peak
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_vld_q <= '0;
			peak_q    <= '0;
		end else if (take_clear || cfg_disable) begin
			bin_vld_q <= '0;
			peak_q    <= '0;
		end else if (wr_en) begin
			bin_vld_q[addr_q] <= 1'b1;
			if (cnt_new > peak_q) begin
				peak_q <= cnt_new;
			end
		end
	end

	// bin memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			bin_mem[addr_q] <= cnt_new;
		end
		if (rd_en) begin
			rd_data_s2 <= bin_mem[rd_addr];
			rd_vld_s2  <= bin_vld_q[rd_addr];
			addr_q     <= rd_addr;
		end
	end

	// luma products
	always_ff @(posedge clk) begin
		if (take_pixel) begin
			red_q   <= req.red;
			green_q <= req.green;
			blue_q  <= req.blue;
		end
		if (state_q == rlh_pkg::ST_MUL) begin
			prod_r_q <= rlh_pkg::PROD_W'(rlh_pkg::WEIGHT_R * red_q);
			prod_g_q <= rlh_pkg::PROD_W'(rlh_pkg::WEIGHT_G * green_q);
			prod_b_q <= rlh_pkg::PROD_W'(rlh_pkg::WEIGHT_B * blue_q);
		end
	end

	// bar height: restoring division of count*150 by peak, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (state_q == rlh_pkg::ST_RD) begin
			count_q <= cnt_now;
			rem_q   <= rlh_pkg::NUM_W'(cnt_now * rlh_pkg::BAR_FULL);
			step_q  <= rlh_pkg::STEP_W'(rlh_pkg::HEIGHT_W - 1);
			quo_q   <= '0;
		end else if (state_q == rlh_pkg::ST_DIV) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				quo_q <= {quo_q[rlh_pkg::HEIGHT_W-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[rlh_pkg::HEIGHT_W-2:0], 1'b0};
			end
			step_q <= step_q - 1'b1;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_q.bin_count  <= count_q;
			rsp_q.bar_height <= height;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== verif/region_luma_histogram_top_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for region_luma_histogram_top: clocked driver, receiver and monitor
// around a bit-exact histogram predictor. Depends on rlh_pkg and the top-level RTL only.
module region_luma_histogram_top_test;
	import rlh_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int IDLE_PCT       = 21;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 24;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_ITEMS   = 700;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	region_luma_histogram_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predicted block state
	logic [BIN_W-1:0] bin_tally [BINS];
	logic [BIN_W-1:0] peak_tally = '0;
	int unsigned col_at = 0;
	int unsigned row_at = 0;
	logic en_reg = 1'b0;
	logic [FIRST_W-1:0] x_first_reg = '0;
	logic [END_W-1:0] x_end_reg = '0;
	logic [FIRST_W-1:0] y_first_reg = '0;
	logic [END_W-1:0] y_end_reg = '0;

	req_t pending_reqs [$];
	rsp_t expected_bins [$];

	logic req_fired = 1'b0;
	int send_idle_pct = IDLE_PCT;
	int recv_idle_pct = IDLE_PCT;
	int hold_asks = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int error_count = 0;
	int random_items = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic [LUMA_W-1:0] luma_of(input logic [7:0] r, g, b);
		int unsigned acc;
		acc = WEIGHT_R * r + WEIGHT_G * g + WEIGHT_B * b;
		return acc[23:16];
	endfunction

	// window edges may come in either order; the span is min..max-1
	function automatic bit in_range(input int unsigned p, a, b);
		int unsigned lo, hi;
		lo = (a <= b) ? a : b;
		hi = (a <= b) ? b : a;
		return p >= lo && p < hi;
	endfunction

	task automatic empty_bins();
		foreach (bin_tally[i]) bin_tally[i] = '0;
		peak_tally = '0;
	endtask

	task automatic tally_request(input req_t r);
		logic [LUMA_W-1:0] l;
		longint unsigned cnt, q;
		rsp_t e;
		case (r.action)
			ACT_CLEAR: begin
				empty_bins();
				col_at = 0;
				row_at = 0;
			end
			ACT_PIXEL: begin
				if (en_reg && in_range(col_at, x_first_reg, x_end_reg)
						&& in_range(row_at, y_first_reg, y_end_reg)) begin
					l = luma_of(r.red, r.green, r.blue);
					if (bin_tally[l] != BIN_MAX) bin_tally[l] = bin_tally[l] + 1'b1;
					if (bin_tally[l] > peak_tally) peak_tally = bin_tally[l];
				end
				// advance position whether or not the pixel counted
				if (col_at == LINE_WIDTH - 1) begin
					col_at = 0;
					row_at = (row_at == LINE_COUNT - 1) ? 0 : row_at + 1;
				end else begin
					col_at = col_at + 1;
				end
			end
			ACT_READ: begin
				cnt = bin_tally[r.bin_index];
				q = 0;
				if (peak_tally != 0) begin
					q = (cnt * BAR_FULL) / peak_tally;
					if (q > BAR_FULL) q = BAR_FULL;
				end
				e.bin_count = cnt[BIN_W-1:0];
				e.bar_height = q[HEIGHT_W-1:0];
				expected_bins.push_back(e);
			end
			default: ;
		endcase
	endtask

	// driver: present the next request once the current one is taken
	always @(negedge clk) begin
		if (arst_n && (!req_valid || req_fired)) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				req_valid <= 1'b1;
				req <= pending_reqs.pop_front();
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, plus a long hold-off when asked
	always @(negedge clk) begin
		if (hold_asks != hold_seen) begin
			hold_seen <= hold_asks;
			hold_left <= HOLD_CYCLES;
			rsp_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin : monitor
		rsp_t want;
		if (arst_n) begin
			req_fired <= req_valid && !req_stall;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ENABLE: begin
						en_reg = cfg_data[0];
						if (!en_reg) empty_bins();
					end
					REG_X_FIRST: x_first_reg = cfg_data[FIRST_W-1:0];
					REG_X_END:   x_end_reg = cfg_data[END_W-1:0];
					REG_Y_FIRST: y_first_reg = cfg_data[FIRST_W-1:0];
					REG_Y_END:   y_end_reg = cfg_data[END_W-1:0];
					default: ;
				endcase
			end
			if (rsp_valid && !rsp_stall) begin
				if (expected_bins.size() == 0) begin
					$display("%0t: response with no read waiting: count %0d height %0d",
						$time, rsp.bin_count, rsp.bar_height);
					error_count++;
				end else begin
					want = expected_bins.pop_front();
					if (rsp.bin_count !== want.bin_count) begin
						$display("%0t: bin_count expected %0d actual %0d",
							$time, want.bin_count, rsp.bin_count);
						error_count++;
					end
					if (rsp.bar_height !== want.bar_height) begin
						$display("%0t: bar_height expected %0d actual %0d",
							$time, want.bar_height, rsp.bar_height);
						error_count++;
					end
				end
			end
			if (req_valid && !req_stall) tally_request(req);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
				$display("Verification failed");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic push_item(input logic [1:0] act, input logic [7:0] r, g, b, idx);
		req_t it;
		it.action = act;
		it.red = r;
		it.green = g;
		it.blue = b;
		it.bin_index = idx;
		pending_reqs.push_back(it);
	endtask

	// hold until every request is taken and every read answered, then let the pipe settle
	task automatic wait_idle();
		do @(posedge clk); while (pending_reqs.size() != 0 || req_valid || expected_bins.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one frame: optional clear, pixels drawn mostly from a small palette with an occasional unused action, then reads
	task automatic push_frame(input int npix, input int nreads, input bit with_clear);
		logic [7:0] pal_r [4];
		logic [7:0] pal_g [4];
		logic [7:0] pal_b [4];
		int k, c;
		for (k = 0; k < 4; k++) begin
			pal_r[k] = 8'($urandom);
			pal_g[k] = 8'($urandom);
			pal_b[k] = 8'($urandom);
		end
		if (with_clear) push_item(ACT_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		for (k = 0; k < npix; k++) begin
			c = $urandom_range(3);
			if ($urandom_range(9) < 8)
				push_item(ACT_PIXEL, pal_r[c], pal_g[c], pal_b[c], 8'($urandom));
			else
				push_item(ACT_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
			if ($urandom_range(49) == 0)
				push_item(ACT_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		end
		for (k = 0; k < nreads; k++) begin
			c = $urandom_range(3);
			if ($urandom_range(9) < 7)
				push_item(ACT_READ, 8'($urandom), 8'($urandom), 8'($urandom),
					luma_of(pal_r[c], pal_g[c], pal_b[c]));
			else
				push_item(ACT_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		end
		random_items += npix + nreads + int'(with_clear);
	endtask

	task automatic run_phase(input int p);
		int kind, f, frames;
		logic [CFG_DATA_W-1:0] xf, xe, yf, ye;
		kind = $urandom_range(5);
		if (p == 1) kind = 1;
		if (p == 4) kind = 0;
		case (kind)
			0: begin
				xf = '0;
				xe = CFG_DATA_W'(1024);
				yf = '0;
				ye = CFG_DATA_W'(1024);
			end
			1: begin
				xf = CFG_DATA_W'(1023);
				xe = CFG_DATA_W'(1024);
				yf = '0;
				ye = CFG_DATA_W'(2);
			end
			2: begin
				xe = CFG_DATA_W'($urandom_range(0, 40));
				xf = xe + CFG_DATA_W'($urandom_range(1, 30));
				yf = CFG_DATA_W'(1);
				ye = '0;
			end
			3: begin
				xf = CFG_DATA_W'($urandom_range(0, 1023));
				xe = xf;
				yf = '0;
				ye = CFG_DATA_W'(2);
			end
			4: begin
				xf = CFG_DATA_W'($urandom);
				xe = CFG_DATA_W'($urandom);
				yf = CFG_DATA_W'($urandom);
				ye = CFG_DATA_W'($urandom);
			end
			default: begin
				xf = CFG_DATA_W'($urandom_range(0, 30));
				xe = CFG_DATA_W'($urandom_range(0, 70));
				yf = CFG_DATA_W'($urandom_range(0, 1));
				ye = CFG_DATA_W'($urandom_range(0, 2));
			end
		endcase
		write_reg(REG_X_FIRST, xf);
		write_reg(REG_X_END, xe);
		write_reg(REG_Y_FIRST, yf);
		write_reg(REG_Y_END, ye);
		write_reg(REG_ENABLE, {10'($urandom), ($urandom_range(99) < 85) ? 1'b1 : 1'b0});
		if ($urandom_range(3) == 0)
			write_reg(CFG_IDX_W'($urandom_range(int'(REG_Y_END) + 1, 2**CFG_IDX_W - 1)),
				CFG_DATA_W'($urandom));
		@(posedge clk);
		if (p == 2) begin
			send_idle_pct <= 0;
			recv_idle_pct <= 0;
		end
		if (p == 3) begin
			hold_asks <= hold_asks + 1;
			push_frame(8, 40, 1'b1);
		end
		frames = $urandom_range(1, 3);
		for (f = 0; f < frames; f++)
			push_frame($urandom_range(5, 40), $urandom_range(2, 10), $urandom_range(4) != 0);
		wait_idle();
		send_idle_pct <= IDLE_PCT;
		recv_idle_pct <= IDLE_PCT;
	endtask

	initial begin : stimulus
		int p, k;
		empty_bins();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: collection off, peak zero
		push_item(ACT_READ, 8'd0, 8'd0, 8'd0, 8'd0);
		push_item(ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		push_item(ACT_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		push_item(ACT_READ, 8'd0, 8'd0, 8'd0, 8'hFE);
		wait_idle();

		write_reg(REG_ENABLE, CFG_DATA_W'(1));
		write_reg(REG_X_FIRST, CFG_DATA_W'(0));
		write_reg(REG_X_END, CFG_DATA_W'(1024));
		write_reg(REG_Y_FIRST, CFG_DATA_W'(0));
		write_reg(REG_Y_END, CFG_DATA_W'(1024));
		@(posedge clk);
		push_item(ACT_CLEAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		push_item(ACT_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0);
		push_item(ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'd0);
		push_item(ACT_PIXEL, 8'hFF, 8'd0, 8'd0, 8'd0);
		push_item(ACT_PIXEL, 8'd0, 8'hFF, 8'd0, 8'd0);
		push_item(ACT_PIXEL, 8'd0, 8'd0, 8'hFF, 8'd0);
		push_item(ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'd0);
		push_item(ACT_READ, 8'hFF, 8'hFF, 8'hFF, 8'd0);
		push_item(ACT_READ, 8'd0, 8'd0, 8'd0, luma_of(8'hFF, 8'hFF, 8'hFF));
		push_item(ACT_READ, 8'd0, 8'd0, 8'd0, luma_of(8'hFF, 8'd0, 8'd0));
		push_item(ACT_READ, 8'd0, 8'd0, 8'd0, luma_of(8'd0, 8'hFF, 8'd0));
		push_item(ACT_READ, 8'd0, 8'd0, 8'd0, luma_of(8'd0, 8'd0, 8'hFF));
		push_item(ACT_READ, 8'd0, 8'd0, 8'd0, 8'hFF);
		wait_idle();

		// disabling empties the bins but keeps the position
		write_reg(REG_ENABLE, CFG_DATA_W'(0));
		@(posedge clk);
		push_item(ACT_READ, 8'd0, 8'd0, 8'd0, luma_of(8'hFF, 8'hFF, 8'hFF));
		push_item(ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'd0);
		wait_idle();

		// reversed edges on both axes, and writes to indexes past the last register
		write_reg(REG_ENABLE, CFG_DATA_W'(1));
		write_reg(REG_X_FIRST, CFG_DATA_W'(1023));
		write_reg(REG_X_END, CFG_DATA_W'(0));
		write_reg(REG_Y_FIRST, CFG_DATA_W'(1023));
		write_reg(REG_Y_END, CFG_DATA_W'(0));
		for (k = int'(REG_Y_END) + 1; k < 2**CFG_IDX_W; k++)
			write_reg(CFG_IDX_W'(k), {CFG_DATA_W{1'b1}});
		@(posedge clk);
		push_item(ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'd0);
		push_item(ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'd0);
		push_item(ACT_READ, 8'd0, 8'd0, 8'd0, luma_of(8'hFF, 8'hFF, 8'hFF));
		wait_idle();

		// empty window on the column axis
		write_reg(REG_X_FIRST, CFG_DATA_W'(7));
		write_reg(REG_X_END, CFG_DATA_W'(7));
		@(posedge clk);
		push_item(ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'd0);
		push_item(ACT_READ, 8'd0, 8'd0, 8'd0, luma_of(8'hFF, 8'hFF, 8'hFF));
		wait_idle();

		p = 0;
		while (random_items < RANDOM_ITEMS || p < 6) begin
			run_phase(p);
			p++;
		end

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_bins.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
design/rlh_pkg.sv
design/region_luma_histogram_top.sv
verif/region_luma_histogram_top_test.sv
